### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands used in the RTL top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Assert a property on the rising clock edge, off while in reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a condition never holds on the rising clock edge
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### src/chf_pkg.sv
// ----------------------------------------------------------------------------
// chf_pkg
// Types and constants for the command handshake channel block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chf_pkg;

  // Sizes
  localparam int CHANNELS   = 8;
  localparam int IDX_W      = 3;
  localparam int CH_W       = 3;
  localparam int CMD_W      = 32;
  localparam int WORD_W     = 32;
  localparam int EVT_W      = 5;
  localparam int MAX_EVENTS = 16;
  localparam int CNT_W      = 16;

  // Channel handshake state
  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_SENDING = 2'd1,
    ST_DONE    = 2'd2,
    ST_ERROR   = 2'd3
  } chf_state_e;

  // Class of a command word change
  typedef enum logic [1:0] {
    CL_SAME    = 2'd0,
    CL_RISING  = 2'd1,
    CL_FALLING = 2'd2,
    CL_OTHER   = 2'd3
  } chf_class_e;

  // One input item
  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [WORD_W-1:0] command_word;
    logic [WORD_W-1:0] data_word;
    logic [EVT_W-1:0]  matched_events;
    logic [EVT_W-1:0]  new_replies;
  } chf_item_t;

  // One result item
  typedef struct packed {
    logic              ack_valid;
    logic [WORD_W-1:0] ack_command;
    logic [WORD_W-1:0] ack_data;
    chf_state_e        channel_state;
  } chf_result_t;

  // Stored context of one channel
  typedef struct packed {
    chf_state_e       state;
    logic [CMD_W-1:0] prev_command;
    logic [CNT_W-1:0] trigger_count;
    logic [CNT_W-1:0] reply_count;
  } chf_entry_t;

  // Step outcome handed to the channel store and the result register
  typedef struct packed {
    logic        wr_en;
    chf_entry_t  entry;
    chf_result_t result;
  } chf_update_t;

  // Classify a word change against the stored word
  function automatic chf_class_e classify(logic [CMD_W-1:0] prev, logic [CMD_W-1:0] cur);
    chf_class_e c;
    if (prev == cur) begin
      c = CL_SAME;
    end else if (prev == '0) begin
      c = CL_RISING;
    end else if (cur == '0) begin
      c = CL_FALLING;
    end else begin
      c = CL_OTHER;
    end
    return c;
  endfunction

  // Limit an incoming event count
  function automatic logic [EVT_W-1:0] clamp_events(logic [EVT_W-1:0] v);
    return (v > EVT_W'(MAX_EVENTS)) ? EVT_W'(MAX_EVENTS) : v;
  endfunction

  // Saturating counter add
  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [EVT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W+1)'(b);
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

endpackage

### src/chf_in_if.sv
// ----------------------------------------------------------------------------
// chf_in_if
// Input channel: one command sample per item, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface chf_in_if;
  import chf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [WORD_W-1:0] command_word;
  logic [WORD_W-1:0] data_word;
  logic [EVT_W-1:0]  matched_events;
  logic [EVT_W-1:0]  new_replies;

  modport source (
    output valid, channel, command_word, data_word, matched_events, new_replies,
    input  ready
  );

  modport sink (
    input  valid, channel, command_word, data_word, matched_events, new_replies,
    output ready
  );
endinterface

### src/chf_out_if.sv
// ----------------------------------------------------------------------------
// chf_out_if
// Result channel: acknowledge and channel state, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface chf_out_if;
  import chf_pkg::*;

  logic              valid;
  logic              ready;
  logic              ack_valid;
  logic [WORD_W-1:0] ack_command;
  logic [WORD_W-1:0] ack_data;
  logic [1:0]        channel_state;

  modport source (
    output valid, ack_valid, ack_command, ack_data, channel_state,
    input  ready
  );

  modport sink (
    input  valid, ack_valid, ack_command, ack_data, channel_state,
    output ready
  );
endinterface

### src/chf_chan_store.sv
// ----------------------------------------------------------------------------
// chf_chan_store
// Per-channel context registers: one read port, one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chf_chan_store (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [chf_pkg::IDX_W-1:0] idx_i,
  output chf_pkg::chf_entry_t     rd_entry_o,
  input  chf_pkg::chf_update_t    upd_i
);
  import chf_pkg::*;

  chf_entry_t ctx_q [CHANNELS];

  // Read the addressed channel
  assign rd_entry_o = ctx_q[idx_i];

  // Write back the updated context; reset puts every channel in READY
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ctx_q[i] <= '{state: ST_READY, prev_command: '0, trigger_count: '0,
                      reply_count: '0};
      end
    end else if (upd_i.wr_en) begin
      ctx_q[idx_i] <= upd_i.entry;
    end
  end
endmodule

### src/chf_step.sv
// ----------------------------------------------------------------------------
// chf_step
// One channel step: classify the word, run the handshake machine, form the ack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chf_step (
  input  chf_pkg::chf_item_t   item_i,
  input  logic                 fire_i,
  input  chf_pkg::chf_entry_t  entry_i,
  output chf_pkg::chf_update_t upd_o
);
  import chf_pkg::*;

  logic [CMD_W-1:0] cur;
  logic [EVT_W-1:0] matched;
  logic [EVT_W-1:0] replies;
  logic             ch_ok;
  chf_class_e       cls;
  logic [CNT_W-1:0] trig_sum;
  logic [CNT_W-1:0] reply_sum;
  logic [CNT_W-1:0] trig_eff;
  logic             send_step;
  logic             ack;
  chf_state_e       st_n;
  chf_entry_t       ent_n;

  // Decode the sample
  assign cur       = CMD_W'(item_i.command_word);
  assign matched   = clamp_events(item_i.matched_events);
  assign replies   = clamp_events(item_i.new_replies);
  assign ch_ok     = (32'(item_i.channel) < 32'(CHANNELS));
  assign cls       = classify(entry_i.prev_command, cur);
  assign trig_sum  = sat_add(entry_i.trigger_count, matched);
  assign reply_sum = sat_add(entry_i.reply_count, replies);

  // Handshake machine; a READY trigger falls through into the SENDING check
  always_comb begin
    ack       = 1'b0;
    st_n      = entry_i.state;
    send_step = 1'b0;
    trig_eff  = entry_i.trigger_count;
    ent_n     = entry_i;

    unique case (entry_i.state)
      ST_ERROR: begin
        if (cls == CL_FALLING) st_n = ST_READY;
      end
      ST_READY: begin
        if (cls == CL_RISING) begin
          trig_eff            = trig_sum;
          ent_n.trigger_count = trig_sum;
          if (trig_sum != '0) begin
            send_step = 1'b1;
          end else begin
            ack  = 1'b1;
            st_n = ST_DONE;
          end
        end
      end
      ST_SENDING: begin
        if (cls != CL_SAME) begin
          st_n = ST_ERROR;
        end else begin
          send_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (cls == CL_FALLING) begin
          ack  = 1'b1;
          st_n = ST_READY;
        end else if (cls != CL_SAME) begin
          st_n = ST_ERROR;
        end
      end
      default: st_n = entry_i.state;
    endcase

    // Count replies; complete when they match the triggers
    if (send_step) begin
      st_n              = ST_SENDING;
      ent_n.reply_count = reply_sum;
      if (reply_sum == trig_eff) begin
        ent_n.reply_count   = '0;
        ent_n.trigger_count = '0;
        ack                 = 1'b1;
        st_n                = ST_DONE;
      end
    end

    ent_n.state        = st_n;
    ent_n.prev_command = cur;
  end

  // Drive the store write and the result
  always_comb begin
    upd_o.wr_en = fire_i && ch_ok;
    upd_o.entry = ent_n;
    upd_o.result = '{ack_valid: 1'b0, ack_command: '0, ack_data: '0,
                     channel_state: ST_READY};
    if (ch_ok) begin
      upd_o.result.channel_state = st_n;
      if (ack) begin
        upd_o.result.ack_valid   = 1'b1;
        upd_o.result.ack_command = WORD_W'(cur);
        upd_o.result.ack_data    = item_i.data_word;
      end
    end
  end
endmodule

### src/command_handshake_channel_fsm.sv
// ----------------------------------------------------------------------------
// command_handshake_channel_fsm
// Per-channel command handshake with change detection and echo acknowledge.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | handshake
//  in_i     | in  | channel, command_word, data_word, matched_events,| valid/ready
//           |     | new_replies                                     |
//  out_o    | out | ack_valid, ack_command, ack_data, channel_state | valid/ready
//
// One item per clock while out_o.ready holds; items pass the input register, then
// the channel step into the result register. Items to the same channel may follow
// back to back: the context write lands on the edge the next item is sampled.
// Reset clears all eight channel contexts at once; items are taken right after.
// A stalled result holds both stages; in_i.ready drops only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module command_handshake_channel_fsm (
  input logic clk_i,
  input logic rst_ni,
  chf_in_if.sink    in_i,
  chf_out_if.source out_o
);
  import chf_pkg::*;

  logic        adv;
  logic        s1_valid_q;
  logic        s1_valid_d;
  chf_item_t   item_q;
  chf_item_t   item_d;
  logic        out_valid_q;
  logic        out_valid_d;
  chf_result_t res_q;
  chf_result_t res_d;
  chf_entry_t  rd_entry;
  chf_update_t upd;

  // Stage 1 moves when the result register is free or drained
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || adv;

  // Input register
  always_comb begin
    item_d     = item_q;
    s1_valid_d = s1_valid_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
      item_d     = '{channel: in_i.channel, command_word: in_i.command_word,
                     data_word: in_i.data_word, matched_events: in_i.matched_events,
                     new_replies: in_i.new_replies};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  // Channel context and step logic
  chf_chan_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .idx_i      (item_q.channel[IDX_W-1:0]),
    .rd_entry_o (rd_entry),
    .upd_i      (upd)
  );

  chf_step u_step (
    .item_i  (item_q),
    .fire_i  (s1_valid_q && adv),
    .entry_i (rd_entry),
    .upd_o   (upd)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (adv) begin
      out_valid_d = s1_valid_q;
      if (s1_valid_q) res_d = upd.result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.ack_valid     = res_q.ack_valid;
  assign out_o.ack_command   = res_q.ack_command;
  assign out_o.ack_data      = res_q.ack_data;
  assign out_o.channel_state = res_q.channel_state;

  // Checks
  `ASSERT_CLK(a_ack_state, (out_valid_q && res_q.ack_valid) |-> (res_q.channel_state == ST_DONE || res_q.channel_state == ST_READY), "ack with channel not in DONE or READY")
  `ASSERT_CLK(a_noack_zero, (out_valid_q && !res_q.ack_valid) |-> (res_q.ack_command == '0 && res_q.ack_data == '0), "echo words nonzero without ack")
  `ASSERT_CLK(a_step_lands, (s1_valid_q && adv) |=> out_valid_q, "stepped item missing from result register")
  `ASSERT_CLK(a_hold_stage, (s1_valid_q && !adv) |=> (s1_valid_q && $stable(item_q)), "input stage changed while stalled")
  `ASSERT_NEVER(a_write_stall, upd.wr_en && !adv, "context written while result stalled")
endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for command_handshake_channel_fsm. A per-channel
// predictor tracks state, stored word and both counters; every accepted
// result is compared in order against the expected acknowledge and state.
// Stimulus: a directed table, a long counter run, then random items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import chf_pkg::*;

  typedef struct {
    chf_item_t   item;
    bit          typed;
    chf_result_t want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  chf_in_if  in_if ();
  chf_out_if out_if ();

  command_handshake_channel_fsm uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted per-channel context
  chf_state_e       chan_st  [CHANNELS];
  logic [CMD_W-1:0] last_cmd [CHANNELS];
  logic [CNT_W-1:0] trig_cnt [CHANNELS];
  logic [CNT_W-1:0] resp_cnt [CHANNELS];

  chf_result_t pending_acks [$];
  plan_row_t   plan [$];
  int          fail_count;
  int unsigned src_gap_pct;
  int unsigned snk_stall_pct;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Class the change of the command word
  function automatic chf_class_e word_change(logic [CMD_W-1:0] prev, logic [CMD_W-1:0] cur);
    chf_class_e c;
    c = CL_OTHER;
    if (prev == cur) c = CL_SAME;
    else if (~|prev) c = CL_RISING;
    else if (~|cur) c = CL_FALLING;
    return c;
  endfunction

  // Clamp an incoming count to the event limit
  function automatic int unsigned limit_count(logic [EVT_W-1:0] v);
    return (int'(v) > MAX_EVENTS) ? MAX_EVENTS : int'(v);
  endfunction

  // Saturating counter add
  function automatic logic [CNT_W-1:0] bump_count(logic [CNT_W-1:0] cnt, int unsigned add);
    int unsigned s;
    s = 32'(cnt) + add;
    return (s > 32'hFFFF) ? '1 : s[CNT_W-1:0];
  endfunction

  // Run one item through the channel and return the expected result
  function automatic chf_result_t advance_channel(chf_item_t it);
    chf_result_t      res;
    chf_state_e       st;
    logic [CMD_W-1:0] cur;
    int unsigned      ch;
    bit               ack;
    ch  = 32'(it.channel);
    cur = it.command_word;
    st  = chan_st[ch];
    ack = 1'b0;
    // error waits for the word to fall
    if (st == ST_ERROR) begin
      if (word_change(last_cmd[ch], cur) == CL_FALLING) st = ST_READY;
      last_cmd[ch] = cur;
    end
    // ready arms on a rising word
    if (st == ST_READY) begin
      if (word_change(last_cmd[ch], cur) == CL_RISING) begin
        trig_cnt[ch] = bump_count(trig_cnt[ch], limit_count(it.matched_events));
        if (trig_cnt[ch] != '0) begin
          st = ST_SENDING;
        end else begin
          ack = 1'b1;
          st  = ST_DONE;
        end
      end
      last_cmd[ch] = cur;
    end
    // sending collects replies until they match the triggers
    if (st == ST_SENDING) begin
      if (word_change(last_cmd[ch], cur) != CL_SAME) begin
        st = ST_ERROR;
      end else begin
        resp_cnt[ch] = bump_count(resp_cnt[ch], limit_count(it.new_replies));
        if (resp_cnt[ch] == trig_cnt[ch]) begin
          resp_cnt[ch] = '0;
          trig_cnt[ch] = '0;
          ack = 1'b1;
          st  = ST_DONE;
        end
      end
      last_cmd[ch] = cur;
    end
    // done acknowledges the falling word
    if (st == ST_DONE) begin
      case (word_change(last_cmd[ch], cur))
        CL_FALLING: begin
          st  = ST_READY;
          ack = 1'b1;
        end
        CL_SAME: ;
        default: st = ST_ERROR;
      endcase
      last_cmd[ch] = cur;
    end
    chan_st[ch]       = st;
    res.ack_valid     = ack;
    res.ack_command   = ack ? cur : '0;
    res.ack_data      = ack ? it.data_word : '0;
    res.channel_state = st;
    return res;
  endfunction

  // Build one item from its fields
  function automatic chf_item_t make_item(int unsigned ch, logic [WORD_W-1:0] cmd,
                                          logic [WORD_W-1:0] data, int unsigned m,
                                          int unsigned r);
    chf_item_t it;
    it.channel        = CH_W'(ch);
    it.command_word   = cmd;
    it.data_word      = data;
    it.matched_events = EVT_W'(m);
    it.new_replies    = EVT_W'(r);
    return it;
  endfunction

  // Append a directed row; typed rows carry their own expectation
  task automatic plan_row(int unsigned ch, logic [WORD_W-1:0] cmd, logic [WORD_W-1:0] data,
                          int unsigned m, int unsigned r, bit typed, bit ack,
                          logic [WORD_W-1:0] acmd, logic [WORD_W-1:0] adata,
                          chf_state_e st);
    plan_row_t row;
    row.item                = make_item(ch, cmd, data, m, r);
    row.typed               = typed;
    row.want.ack_valid      = ack;
    row.want.ack_command    = acmd;
    row.want.ack_data       = adata;
    row.want.channel_state  = st;
    plan.push_back(row);
  endtask

  // Drive one item, wait for its handshake, then record the expectation
  task automatic drive_item(chf_item_t it, bit typed, chf_result_t want);
    chf_result_t exp_res;
    while ($urandom_range(99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.channel        <= it.channel;
    in_if.command_word   <= it.command_word;
    in_if.data_word      <= it.data_word;
    in_if.matched_events <= it.matched_events;
    in_if.new_replies    <= it.new_replies;
    do @(posedge clk_i); while (!in_if.ready);
    exp_res = advance_channel(it);
    if (typed) exp_res = want;
    pending_acks.push_back(exp_res);
  endtask

  // Hold the sender until every expected result is back
  task automatic drain_acks();
    in_if.valid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk_i);
  endtask

  // Random item shaped by the predicted channel state
  function automatic chf_item_t random_item();
    int unsigned      ch;
    int unsigned      pick;
    int unsigned      m;
    int unsigned      r;
    logic [WORD_W-1:0] cmd;
    ch   = $urandom_range(CHANNELS - 1);
    pick = $urandom_range(99);
    if (pick < 40) cmd = last_cmd[ch];
    else if (pick < 65) cmd = '0;
    else if (pick < 80) cmd = WORD_W'(1) << $urandom_range(WORD_W - 1);
    else cmd = $urandom();
    m = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(3);
    r = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(4);
    // close out a pending handshake now and then
    if (chan_st[ch] == ST_SENDING && trig_cnt[ch] > resp_cnt[ch] &&
        trig_cnt[ch] - resp_cnt[ch] <= 31 && $urandom_range(99) < 35)
      r = 32'(trig_cnt[ch] - resp_cnt[ch]);
    return make_item(ch, cmd, $urandom(), m, r);
  endfunction

  // Result checker and receiver stalls
  initial begin
    chf_result_t exp_res;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_acks.size() == 0) begin
          $error("unexpected result: ack_valid %0b state %0d", out_if.ack_valid,
                 out_if.channel_state);
          fail_count++;
        end else begin
          exp_res = pending_acks.pop_front();
          if (out_if.ack_valid !== exp_res.ack_valid) begin
            $error("ack_valid: expected %0h, got %0h", exp_res.ack_valid, out_if.ack_valid);
            fail_count++;
          end
          if (out_if.ack_command !== exp_res.ack_command) begin
            $error("ack_command: expected %0h, got %0h", exp_res.ack_command,
                   out_if.ack_command);
            fail_count++;
          end
          if (out_if.ack_data !== exp_res.ack_data) begin
            $error("ack_data: expected %0h, got %0h", exp_res.ack_data, out_if.ack_data);
            fail_count++;
          end
          if (out_if.channel_state !== exp_res.channel_state) begin
            $error("channel_state: expected %0h, got %0h", exp_res.channel_state,
                   out_if.channel_state);
            fail_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Stimulus
  initial begin
    chf_result_t none;
    none                 = '0;
    fail_count           = 0;
    src_gap_pct          = 9;
    snk_stall_pct        = 60;
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.channel        = '0;
    in_if.command_word   = '0;
    in_if.data_word      = '0;
    in_if.matched_events = '0;
    in_if.new_replies    = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      chan_st[i]  = ST_READY;
      last_cmd[i] = '0;
      trig_cnt[i] = '0;
      resp_cnt[i] = '0;
    end

    // ch, cmd, data, matched, replies, typed, ack, ack cmd, ack data, state
    plan_row(0, 32'h0,        32'hFFFF_FFFF, 0,  0,  1, 0, 32'h0, 32'h0, ST_READY);
    plan_row(7, 32'hFFFF_FFFF, 32'h0,        0,  31, 1, 1, 32'hFFFF_FFFF, 32'h0, ST_DONE);
    plan_row(7, 32'hFFFF_FFFF, 32'h1,        0,  0,  1, 0, 32'h0, 32'h0, ST_DONE);
    plan_row(7, 32'h0,        32'hA5A5_A5A5, 0,  0,  1, 1, 32'h0, 32'hA5A5_A5A5, ST_READY);
    // clamped trigger count, then clamped replies close it
    plan_row(1, 32'h1,        32'h1234_5678, 31, 0,  1, 0, 32'h0, 32'h0, ST_SENDING);
    plan_row(1, 32'h1,        32'h0,         0,  31, 1, 1, 32'h1, 32'h0, ST_DONE);
    plan_row(1, 32'h8000_0000, 32'h0,        0,  0,  1, 0, 32'h0, 32'h0, ST_ERROR);
    plan_row(1, 32'h5,        32'h0,         0,  0,  1, 0, 32'h0, 32'h0, ST_ERROR);
    plan_row(1, 32'h0,        32'h0,         0,  0,  1, 0, 32'h0, 32'h0, ST_READY);
    // ready to sending to done in one step
    plan_row(2, 32'h7,        32'hDEAD_BEEF, 1,  1,  1, 1, 32'h7, 32'hDEAD_BEEF, ST_DONE);
    plan_row(2, 32'h3,        32'h0,         0,  0,  0, 0, 32'h0, 32'h0, ST_READY);
    plan_row(2, 32'h0,        32'h0,         0,  0,  0, 0, 32'h0, 32'h0, ST_READY);
    // reply surplus keeps the channel sending
    plan_row(3, 32'hA,        32'h5555_AAAA, 2,  0,  0, 0, 32'h0, 32'h0, ST_READY);
    plan_row(3, 32'hA,        32'h0,         0,  5,  0, 0, 32'h0, 32'h0, ST_READY);
    plan_row(3, 32'hA,        32'h0,         0,  16, 0, 0, 32'h0, 32'h0, ST_READY);
    plan_row(3, 32'h0,        32'h0,         0,  0,  0, 0, 32'h0, 32'h0, ST_READY);
    plan_row(3, 32'h0,        32'h0,         0,  0,  0, 0, 32'h0, 32'h0, ST_READY);
    plan_row(3, 32'h9,        32'h0,         0,  0,  0, 0, 32'h0, 32'h0, ST_READY);
    plan_row(3, 32'h0,        32'h0,         0,  0,  0, 0, 32'h0, 32'h0, ST_READY);
    // interleave two channels
    plan_row(4, 32'h2,        32'h0F0F_0F0F, 3,  0,  0, 0, 32'h0, 32'h0, ST_READY);
    plan_row(5, 32'h2,        32'hF0F0_F0F0, 0,  0,  0, 0, 32'h0, 32'h0, ST_READY);
    plan_row(4, 32'h2,        32'h3C3C_3C3C, 0,  3,  0, 0, 32'h0, 32'h0, ST_READY);
    plan_row(4, 32'h2,        32'h0,         0,  0,  0, 0, 32'h0, 32'h0, ST_READY);
    plan_row(6, 32'h0,        32'h0,         16, 16, 0, 0, 32'h0, 32'h0, ST_READY);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (plan[i]) drive_item(plan[i].item, plan[i].typed, plan[i].want);

    // Pump the trigger count of channel 6 well past one item's worth
    for (int n = 0; n < 100; n++) begin
      drive_item(make_item(6, 32'h1, $urandom(), 16, 0), 1'b0, none);
      drive_item(make_item(6, 32'h2, $urandom(), 0, 0), 1'b0, none);
      drive_item(make_item(6, 32'h0, $urandom(), 0, 0), 1'b0, none);
    end
    // Arm it, then let replies build up until they meet the triggers
    drive_item(make_item(6, 32'h1, $urandom(), 16, 0), 1'b0, none);
    for (int n = 0; n < 110; n++)
      drive_item(make_item(6, 32'h1, $urandom(), 0, 16), 1'b0, none);
    drive_item(make_item(6, 32'h0, $urandom(), 0, 0), 1'b0, none);

    // Random items over three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      drain_acks();
      src_gap_pct   = (ph == 0) ? 9 : (ph == 1) ? 60 : 0;
      snk_stall_pct = (ph == 0) ? 60 : (ph == 1) ? 9 : 0;
      for (int n = 0; n < 488; n++) drive_item(random_item(), 1'b0, none);
    end

    // Wind down
    in_if.valid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### command_handshake_channel_fsm.f
+incdir+src
src/chf_pkg.sv
src/chf_in_if.sv
src/chf_out_if.sv
src/chf_chan_store.sv
src/chf_step.sv
src/command_handshake_channel_fsm.sv
dv/tb.sv
